// ===== rtl/core/anx_pkg.sv =====
package anx_pkg;

  // Result kinds carried on out_tuser
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  // One result as it sits in the result queue
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        forbidden_bit;
    logic [1:0]  ref_idc;
    logic [4:0]  unit_type;
    logic        last;
  } res_t;

  // Most results one stream byte can cause
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_CNT_W = 3;

  // NAL unit types with header extension bytes
  localparam logic [4:0] TYPE_PREFIX  = 5'd14;
  localparam logic [4:0] TYPE_SLC_EXT = 5'd20;
  localparam logic [4:0] TYPE_3D_EXT  = 5'd21;

  // Emulation-prevention byte
  localparam logic [7:0] EPB_BYTE = 8'h03;

endpackage

// ===== rtl/core/annexb_nal_unit_extractor.sv =====
// H.264 Annex B NAL unit extractor. Takes one stream byte per request on the
// in_ side (in_tlast marks the final byte of the stream) and returns a stream
// of results: the NAL header fields after each start code, the RBSP bytes with
// emulation-prevention bytes removed, and an end marker when a unit closes.
// One byte is parsed per cycle while in_tready is high; a byte may cause up to
// four results, which go into a result queue of FIFO_DEPTH entries (a power of
// two, at least 8). in_tready is high while that queue has four free entries,
// and while out_tready is high the queue drains one result per cycle, so the
// byte rate is one per cycle while each byte yields at most one result and
// otherwise follows the result count. out_tlast marks a byte's final result.
module annexb_nal_unit_extractor #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [8] forbidden_bit,
                                  // [10:9] ref_idc, [15:11] unit_type
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

  logic                                  accept;
  anx_pkg::res_t [anx_pkg::MAX_RES-1:0]  res;
  logic [anx_pkg::RES_CNT_W-1:0]         res_cnt;
  logic                                  space_ok;
  anx_pkg::res_t                         head;

  assign in_tready = space_ok;
  assign accept    = in_tvalid && in_tready;

  // Byte parser
  anx_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .stream_byte   (in_tdata),
    .end_of_stream (in_tlast),
    .res           (res),
    .res_cnt       (res_cnt)
  );

  // Result queue
  anx_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (res),
    .push_cnt  (res_cnt),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  // Output packing
  assign out_tdata = {head.unit_type, head.ref_idc, head.forbidden_bit, head.data_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ===== rtl/core/anx_parser.sv =====
module anx_parser (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic [7:0]                             stream_byte,
  input  logic                                   end_of_stream,
  output anx_pkg::res_t [anx_pkg::MAX_RES-1:0]   res,
  output logic [anx_pkg::RES_CNT_W-1:0]          res_cnt
);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  zero_run_r, zero_run_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [1:0]  ext_left_r, ext_left_nxt;
  logic        ext_pend_r, ext_pend_nxt;

  logic        run2;
  logic        is_zero;
  logic        is_one;
  logic [anx_pkg::RES_CNT_W-1:0] cnt;
  anx_pkg::res_t [anx_pkg::MAX_RES-1:0] res_c;

  assign run2    = (zero_run_r >= 2'd2);
  assign is_zero = (stream_byte == 8'h00);
  assign is_one  = (stream_byte == 8'h01);

  // Next state and the results of this byte
  always_comb begin
    phase_nxt    = phase_r;
    zero_run_nxt = zero_run_r;
    held_nxt     = held_r;
    ext_left_nxt = ext_left_r;
    ext_pend_nxt = ext_pend_r;
    res_c        = '0;
    cnt          = '0;

    case (phase_r)
      PH_HEADER: begin
        res_c[cnt[1:0]].kind          = anx_pkg::KIND_HEADER;
        res_c[cnt[1:0]].forbidden_bit = stream_byte[7];
        res_c[cnt[1:0]].ref_idc       = stream_byte[6:5];
        res_c[cnt[1:0]].unit_type     = stream_byte[4:0];
        cnt          = cnt + 3'd1;
        held_nxt     = '0;
        ext_left_nxt = '0;
        ext_pend_nxt = 1'b0;
        zero_run_nxt = is_zero ? 2'd1 : 2'd0;
        if ((stream_byte[4:0] == anx_pkg::TYPE_PREFIX) ||
            (stream_byte[4:0] == anx_pkg::TYPE_SLC_EXT)) begin
          ext_left_nxt = 2'd3;
        end else if (stream_byte[4:0] == anx_pkg::TYPE_3D_EXT) begin
          ext_pend_nxt = 1'b1;
        end
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (run2 && (is_zero || is_one)) begin
          // 00 00 00 or 00 00 01 closes the unit
          res_c[cnt[1:0]].kind = anx_pkg::KIND_END;
          cnt          = cnt + 3'd1;
          held_nxt     = '0;
          ext_left_nxt = '0;
          ext_pend_nxt = 1'b0;
          phase_nxt    = is_zero ? PH_SEARCH : PH_HEADER;
          zero_run_nxt = is_zero ? 2'd2 : 2'd0;
        end else if (ext_pend_r) begin
          // first extension byte of type 21 picks the drop count
          ext_pend_nxt = 1'b0;
          ext_left_nxt = stream_byte[7] ? 2'd1 : 2'd2;
          zero_run_nxt = is_zero ? zero_run_r + 2'd1 : 2'd0;
        end else if (ext_left_r != 2'd0) begin
          ext_left_nxt = ext_left_r - 2'd1;
          zero_run_nxt = is_zero ? zero_run_r + 2'd1 : 2'd0;
        end else if ((stream_byte == anx_pkg::EPB_BYTE) && (held_r >= 2'd2)) begin
          // drop the emulation-prevention byte, release the held zeros
          for (int k = 0; k < 2; k++) begin
            if (2'(k) < held_r) begin
              res_c[cnt[1:0]] = '0;
              cnt = cnt + 3'd1;
            end
          end
          held_nxt     = '0;
          zero_run_nxt = '0;
        end else if (is_zero) begin
          if (held_r < 2'd2) begin
            held_nxt = held_r + 2'd1;
          end
          zero_run_nxt = zero_run_r + 2'd1;
        end else begin
          for (int k = 0; k < 2; k++) begin
            if (2'(k) < held_r) begin
              res_c[cnt[1:0]] = '0;
              cnt = cnt + 3'd1;
            end
          end
          res_c[cnt[1:0]].kind      = anx_pkg::KIND_DATA;
          res_c[cnt[1:0]].data_byte = stream_byte;
          cnt          = cnt + 3'd1;
          held_nxt     = '0;
          zero_run_nxt = '0;
        end
      end
      default: begin
        // searching; the unused code behaves the same
        if (is_zero) begin
          if (zero_run_r < 2'd3) begin
            zero_run_nxt = zero_run_r + 2'd1;
          end
        end else if (is_one && run2) begin
          phase_nxt    = PH_HEADER;
          zero_run_nxt = '0;
        end else begin
          zero_run_nxt = '0;
        end
      end
    endcase

    // End of stream flushes an open unit and clears everything
    if (end_of_stream) begin
      if (phase_nxt == PH_BODY) begin
        for (int k = 0; k < 2; k++) begin
          if (2'(k) < held_nxt) begin
            res_c[cnt[1:0]] = '0;
            cnt = cnt + 3'd1;
          end
        end
        res_c[cnt[1:0]]      = '0;
        res_c[cnt[1:0]].kind = anx_pkg::KIND_END;
        cnt = cnt + 3'd1;
      end
      phase_nxt    = PH_SEARCH;
      zero_run_nxt = '0;
      held_nxt     = '0;
      ext_left_nxt = '0;
      ext_pend_nxt = 1'b0;
    end

    if (cnt != '0) begin
      res_c[2'(cnt - 3'd1)].last = 1'b1;
    end
  end

  assign res     = res_c;
  assign res_cnt = cnt;

  // State registers, updated per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEARCH;
      zero_run_r <= '0;
      held_r     <= '0;
      ext_left_r <= '0;
      ext_pend_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      zero_run_r <= zero_run_nxt;
      held_r     <= held_nxt;
      ext_left_r <= ext_left_nxt;
      ext_pend_r <= ext_pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && end_of_stream |=> (phase_r == PH_SEARCH) && (zero_run_r == 2'd0) &&
                                (held_r == 2'd0) && !ext_pend_r)
    else $error("end of stream did not clear parser state");

  a_held_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_BODY) |-> (held_r == 2'd0) && (ext_left_r == 2'd0))
    else $error("held zeros or extension count outside a NAL body");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt != '0) |-> res[2'(res_cnt - 3'd1)].last)
    else $error("final result of a byte lacks last");
`endif

endmodule

// ===== rtl/core/anx_res_fifo.sv =====
module anx_res_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  anx_pkg::res_t [anx_pkg::MAX_RES-1:0]   push_res,
  input  logic [anx_pkg::RES_CNT_W-1:0]          push_cnt,
  output logic                                   space_ok,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output anx_pkg::res_t                          out_res
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - anx_pkg::MAX_RES);

  anx_pkg::res_t    mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    add;
  logic             pop;

  assign add       = push ? CW'(push_cnt) : '0;
  assign pop       = out_valid && out_ready;
  assign space_ok  = (cnt_r <= ROOM_LIMIT);
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];

  // Entry storage, several writes per request
  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(anx_pkg::MAX_RES); i++) begin
      if (push && (anx_pkg::RES_CNT_W'(i) < push_cnt)) begin
        mem_r[wr_ptr_r + AW'(i)] <= push_res[i];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(add);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_r + add - (pop ? CW'(1) : CW'(0));
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> space_ok)
    else $error("push into result queue without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (add == '0) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop without push did not lower count");
`endif

endmodule
